@@ hdl/redundant_sensor_health_monitor_defines.svh @@
// Assertion macros used by the checker file of the sensor health monitor.
`ifndef REDUNDANT_SENSOR_HEALTH_MONITOR_DEFINES_SVH
`define REDUNDANT_SENSOR_HEALTH_MONITOR_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define RSHM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rshm check failed");

// Antecedent implies consequent in the next cycle.
`define RSHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rshm check failed");

`endif

@@ hdl/rshm_pkg.sv @@
// Shared constants, types and the debounce update of the sensor health monitor.
package rshm_pkg;

    localparam int AVG_WINDOW = 8;
    localparam int CNT_W      = $clog2(AVG_WINDOW + 1);
    localparam int POS_W      = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
    localparam int MAG_W      = 16 + CNT_W;
    localparam int ACC_W      = MAG_W + 1;
    localparam int DIV_CW     = $clog2(MAG_W + 1);
    localparam int N_MON      = 6;
    localparam int N_WIN      = 4;

    localparam logic [7:0] RUN_MAX = 8'd255;

    localparam logic [1:0] WIN_TEMP  = 2'd0;
    localparam logic [1:0] WIN_HUM   = 2'd1;
    localparam logic [1:0] WIN_LIGHT = 2'd2;
    localparam logic [1:0] WIN_CUR   = 2'd3;

    localparam logic [2:0] REG_TEMP_MIN = 3'd0;
    localparam logic [2:0] REG_TEMP_MAX = 3'd1;
    localparam logic [2:0] REG_HUM_MIN  = 3'd2;
    localparam logic [2:0] REG_HUM_MAX  = 3'd3;
    localparam logic [2:0] REG_LUX_MIN  = 3'd4;
    localparam logic [2:0] REG_LUX_MAX  = 3'd5;
    localparam logic [2:0] REG_CUR_LIM  = 3'd6;
    localparam logic [2:0] REG_CONFIRM  = 3'd7;

    localparam logic [1:0] SEV_OK      = 2'd0;
    localparam logic [1:0] SEV_WARNING = 2'd1;
    localparam logic [1:0] SEV_ALARM   = 2'd2;

    localparam logic [2:0] FC_NONE        = 3'd0;
    localparam logic [2:0] FC_BOTH_TEMP   = 3'd1;
    localparam logic [2:0] FC_BOTH_HUM    = 3'd2;
    localparam logic [2:0] FC_LIGHT       = 3'd3;
    localparam logic [2:0] FC_OVERCURRENT = 3'd4;
    localparam logic [2:0] FC_BOTH_BACKUP = 3'd5;
    localparam logic [2:0] FC_TEMP_BACKUP = 3'd6;
    localparam logic [2:0] FC_HUM_BACKUP  = 3'd7;

    typedef struct packed {
        logic [7:0] bad;
        logic [7:0] good;
        logic       ok;
    } t_mon;

    function automatic t_mon mon_update(input t_mon m, input logic good,
                                        input logic [7:0] need);
        t_mon r;
        r = m;
        if (good) begin
            r.bad = 8'd0;
            if (m.good != RUN_MAX) r.good = m.good + 8'd1;
            if (r.good >= need) r.ok = 1'b1;
        end else begin
            r.good = 8'd0;
            if (m.bad != RUN_MAX) r.bad = m.bad + 8'd1;
            if (r.bad >= need) r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ hdl/redundant_sensor_health_monitor.sv @@
// Top level: range checks, debounced health, failover and windowed means.
// From acceptance to the result word: per window a summing pass over the stored samples
// (when empty, the mean is cleared and no division runs), then a start state and the shared
// bit-serial divider; then the actuator monitor and the loading of the outputs.
// A word is taken whenever the sequencer is idle; a waiting result holds it.
// Synchronous active-low reset: primary sources, all sensors healthy, windows empty.
module redundant_sensor_health_monitor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic signed [10:0] i_temp_primary,
    input  logic [9:0]         i_hum_primary,
    input  logic               i_primary_read_ok,
    input  logic signed [10:0] i_temp_backup,
    input  logic [9:0]         i_hum_backup,
    input  logic               i_backup_read_ok,
    input  logic [15:0]        i_light_level,
    input  logic [15:0]        i_actuator_current,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [10:0] o_avg_temp,
    output logic [9:0]         o_avg_hum,
    output logic [15:0]        o_avg_light,
    output logic [15:0]        o_avg_current,
    output logic               o_temp_avg_valid,
    output logic               o_hum_avg_valid,
    output logic               o_climate_ok,
    output logic               o_temp_on_backup,
    output logic               o_hum_on_backup,
    output logic [1:0]         o_severity,
    output logic [2:0]         o_fault_code,
    output logic [5:0]         o_health_flags
);

    typedef enum logic [2:0] {S_IDLE, S_SUM, S_DIVS, S_DIVW, S_FIN, S_OUT} t_state;

    localparam int AW = rshm_pkg::AVG_WINDOW;
    localparam int CW = rshm_pkg::CNT_W;
    localparam int PW = rshm_pkg::POS_W;
    localparam int XW = rshm_pkg::ACC_W;
    localparam int MW = rshm_pkg::MAG_W;

    t_state               r_state;
    logic signed [10:0]   r_tmin, r_tmax;
    logic [9:0]           r_hmin, r_hmax;
    logic [15:0]          r_lmin, r_lmax, r_limit;
    logic [7:0]           r_confirm;
    rshm_pkg::t_mon       r_mon [rshm_pkg::N_MON];
    logic [1:0]           r_src;
    logic [CW-1:0]        r_cnt [rshm_pkg::N_WIN];
    logic [PW-1:0]        r_pos [rshm_pkg::N_WIN];
    logic [15:0]          r_win [rshm_pkg::N_WIN][AW];
    logic [15:0]          r_mean [rshm_pkg::N_WIN];
    logic                 r_mode, r_phase;
    logic [PW-1:0]        r_idx;
    logic signed [XW-1:0] r_acc;
    logic                 r_out_valid;
    logic signed [10:0]   r_o_temp;
    logic [9:0]           r_o_hum;
    logic [15:0]          r_o_light, r_o_cur;
    logic                 r_o_tv, r_o_hv, r_o_cok, r_o_tb, r_o_hb;
    logic [1:0]           r_o_sev;
    logic [2:0]           r_o_code;
    logic [5:0]           r_o_flags;

    logic                 accept;
    logic                 ta_ok, tb_ok, ha_ok, hb_ok, lux_ok;
    rshm_pkg::t_mon       a_mon [rshm_pkg::N_MON];
    logic [1:0]           a_src;
    logic                 a_clr  [rshm_pkg::N_WIN];
    logic                 a_push [rshm_pkg::N_WIN];
    logic [15:0]          a_data [rshm_pkg::N_WIN];
    logic [CW-1:0]        a_cnt  [rshm_pkg::N_WIN];
    logic [PW-1:0]        a_pos  [rshm_pkg::N_WIN];
    logic [PW-1:0]        a_wpos [rshm_pkg::N_WIN];

    logic [1:0]           k;
    logic [15:0]          rd;
    logic signed [XW-1:0] rd_ext;
    logic [MW-1:0]        mag;
    logic [MW-1:0]        quo;
    logic [MW-1:0]        q_signed;
    logic                 div_done;
    logic                 last_sum;

    logic                 both_t, both_h, c_sev_alarm;
    logic [1:0]           c_sev;
    logic [2:0]           c_code;
    logic [5:0]           c_flags;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Sample checks, debounce, failover and window writes for an accepted word.
    always_comb begin
        ta_ok  = i_primary_read_ok && (i_temp_primary >= r_tmin) && (i_temp_primary <= r_tmax);
        tb_ok  = i_backup_read_ok && (i_temp_backup >= r_tmin) && (i_temp_backup <= r_tmax);
        ha_ok  = i_primary_read_ok && (i_hum_primary >= r_hmin) && (i_hum_primary <= r_hmax);
        hb_ok  = i_backup_read_ok && (i_hum_backup >= r_hmin) && (i_hum_backup <= r_hmax);
        lux_ok = (i_light_level >= r_lmin) && (i_light_level <= r_lmax);

        for (int m = 0; m < rshm_pkg::N_MON; m++) a_mon[m] = r_mon[m];
        if (!i_mode) begin
            a_mon[0] = rshm_pkg::mon_update(r_mon[0], ta_ok, r_confirm);
            a_mon[1] = rshm_pkg::mon_update(r_mon[1], tb_ok, r_confirm);
            a_mon[2] = rshm_pkg::mon_update(r_mon[2], ha_ok, r_confirm);
            a_mon[3] = rshm_pkg::mon_update(r_mon[3], hb_ok, r_confirm);
        end else begin
            a_mon[4] = rshm_pkg::mon_update(r_mon[4], lux_ok, r_confirm);
        end

        a_src = r_src;
        if (!i_mode) begin
            for (int q = 0; q < 2; q++) begin
                if (a_mon[2*q].ok) a_src[q] = 1'b0;
                else if (a_mon[2*q+1].ok) a_src[q] = 1'b1;
            end
        end

        a_clr[0]  = !i_mode && (a_src[0] != r_src[0]);
        a_clr[1]  = !i_mode && (a_src[1] != r_src[1]);
        a_clr[2]  = 1'b0;
        a_clr[3]  = 1'b0;
        a_push[0] = !i_mode && (a_src[0] ? tb_ok : ta_ok);
        a_push[1] = !i_mode && (a_src[1] ? hb_ok : ha_ok);
        a_push[2] = i_mode && lux_ok;
        a_push[3] = i_mode;
        a_data[0] = a_src[0] ? 16'($signed(i_temp_backup)) : 16'($signed(i_temp_primary));
        a_data[1] = {6'd0, a_src[1] ? i_hum_backup : i_hum_primary};
        a_data[2] = i_light_level;
        a_data[3] = i_actuator_current;

        for (int w = 0; w < rshm_pkg::N_WIN; w++) begin
            a_wpos[w] = a_clr[w] ? '0 : r_pos[w];
            a_cnt[w]  = a_clr[w] ? '0 : r_cnt[w];
            a_pos[w]  = a_wpos[w];
            if (a_push[w]) begin
                a_pos[w] = (a_wpos[w] == PW'(AW - 1)) ? '0 : a_wpos[w] + 1'b1;
                if (a_cnt[w] < CW'(AW)) a_cnt[w] = a_cnt[w] + 1'b1;
            end
        end
    end

    // Window being summed and divided: climate uses temperature then humidity,
    // a fast sample uses light then current.
    always_comb begin
        k        = {r_mode, r_phase};
        rd       = r_win[k][r_idx];
        rd_ext   = (k == rshm_pkg::WIN_TEMP) ? XW'($signed(rd[10:0]))
                                             : {{(XW-16){1'b0}}, rd};
        mag      = r_acc[XW-1] ? MW'(-r_acc) : MW'(r_acc);
        q_signed = r_acc[XW-1] ? MW'(-quo) : quo;
        last_sum = ({1'b0, r_idx} + 1'b1) == (PW+1)'(r_cnt[k]);
    end

    rshm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVS),
        .i_dividend (mag),
        .i_divisor  (r_cnt[k]),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_comb begin
        both_t      = !r_mon[0].ok && !r_mon[1].ok;
        both_h      = !r_mon[2].ok && !r_mon[3].ok;
        c_sev_alarm = both_t || both_h || !r_mon[4].ok || !r_mon[5].ok;
        if (c_sev_alarm) c_sev = rshm_pkg::SEV_ALARM;
        else if (r_src[0] || r_src[1]) c_sev = rshm_pkg::SEV_WARNING;
        else c_sev = rshm_pkg::SEV_OK;

        if (both_t) c_code = rshm_pkg::FC_BOTH_TEMP;
        else if (both_h) c_code = rshm_pkg::FC_BOTH_HUM;
        else if (!r_mon[4].ok) c_code = rshm_pkg::FC_LIGHT;
        else if (!r_mon[5].ok) c_code = rshm_pkg::FC_OVERCURRENT;
        else if (r_src[0] && r_src[1]) c_code = rshm_pkg::FC_BOTH_BACKUP;
        else if (r_src[0]) c_code = rshm_pkg::FC_TEMP_BACKUP;
        else if (r_src[1]) c_code = rshm_pkg::FC_HUM_BACKUP;
        else c_code = rshm_pkg::FC_NONE;

        for (int m = 0; m < rshm_pkg::N_MON; m++) c_flags[m] = r_mon[m].ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tmin      <= -11'sd400;
            r_tmax      <= 11'sd800;
            r_hmin      <= 10'd0;
            r_hmax      <= 10'd1000;
            r_lmin      <= 16'd0;
            r_lmax      <= 16'hFFFF;
            r_limit     <= 16'd500;
            r_confirm   <= 8'd3;
            r_src       <= 2'b00;
            for (int m = 0; m < rshm_pkg::N_MON; m++) r_mon[m] <= '{8'd0, 8'd0, 1'b1};
            for (int w = 0; w < rshm_pkg::N_WIN; w++) begin
                r_cnt[w]  <= '0;
                r_pos[w]  <= '0;
                r_mean[w] <= 16'd0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rshm_pkg::REG_TEMP_MIN: r_tmin    <= i_cfg_data[10:0];
                    rshm_pkg::REG_TEMP_MAX: r_tmax    <= i_cfg_data[10:0];
                    rshm_pkg::REG_HUM_MIN:  r_hmin    <= i_cfg_data[9:0];
                    rshm_pkg::REG_HUM_MAX:  r_hmax    <= i_cfg_data[9:0];
                    rshm_pkg::REG_LUX_MIN:  r_lmin    <= i_cfg_data;
                    rshm_pkg::REG_LUX_MAX:  r_lmax    <= i_cfg_data;
                    rshm_pkg::REG_CUR_LIM:  r_limit   <= i_cfg_data;
                    rshm_pkg::REG_CONFIRM:  r_confirm <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        for (int m = 0; m < rshm_pkg::N_MON; m++) r_mon[m] <= a_mon[m];
                        r_src <= a_src;
                        for (int w = 0; w < rshm_pkg::N_WIN; w++) begin
                            r_cnt[w] <= a_cnt[w];
                            r_pos[w] <= a_pos[w];
                            if (a_push[w]) r_win[w][a_wpos[w]] <= a_data[w];
                        end
                        r_mode  <= i_mode;
                        r_phase <= 1'b0;
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_cnt[k] == '0) begin
                        r_mean[k] <= 16'd0;
                        r_idx     <= '0;
                        r_acc     <= '0;
                        if (!r_phase) r_phase <= 1'b1;
                        else r_state <= S_FIN;
                    end else begin
                        r_acc <= r_acc + rd_ext;
                        r_idx <= r_idx + 1'b1;
                        if (last_sum) r_state <= S_DIVS;
                    end
                end
                S_DIVS: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_mean[k] <= q_signed[15:0];
                        r_idx     <= '0;
                        r_acc     <= '0;
                        if (!r_phase) begin
                            r_phase <= 1'b1;
                            r_state <= S_SUM;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    // The actuator monitor judges the new mean current.
                    if (r_mode) begin
                        r_mon[5] <= rshm_pkg::mon_update(r_mon[5],
                            !(r_mean[rshm_pkg::WIN_CUR] > r_limit), r_confirm);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // The previous result word must have left before this one is loaded.
                    if (!r_out_valid || !i_out_stall) begin
                        r_o_temp    <= r_mean[rshm_pkg::WIN_TEMP][10:0];
                        r_o_hum     <= r_mean[rshm_pkg::WIN_HUM][9:0];
                        r_o_light   <= r_mean[rshm_pkg::WIN_LIGHT];
                        r_o_cur     <= r_mean[rshm_pkg::WIN_CUR];
                        r_o_tv      <= r_cnt[rshm_pkg::WIN_TEMP] != '0;
                        r_o_hv      <= r_cnt[rshm_pkg::WIN_HUM] != '0;
                        r_o_cok     <= (r_mon[0].ok || r_mon[1].ok)
                                    && (r_cnt[rshm_pkg::WIN_TEMP] != '0)
                                    && (r_mon[2].ok || r_mon[3].ok)
                                    && (r_cnt[rshm_pkg::WIN_HUM] != '0);
                        r_o_tb      <= r_src[0];
                        r_o_hb      <= r_src[1];
                        r_o_sev     <= c_sev;
                        r_o_code    <= c_code;
                        r_o_flags   <= c_flags;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_avg_temp       = r_o_temp;
    assign o_avg_hum        = r_o_hum;
    assign o_avg_light      = r_o_light;
    assign o_avg_current    = r_o_cur;
    assign o_temp_avg_valid = r_o_tv;
    assign o_hum_avg_valid  = r_o_hv;
    assign o_climate_ok     = r_o_cok;
    assign o_temp_on_backup = r_o_tb;
    assign o_hum_on_backup  = r_o_hb;
    assign o_severity       = r_o_sev;
    assign o_fault_code     = r_o_code;
    assign o_health_flags   = r_o_flags;

endmodule

@@ hdl/rshm_div.sv @@
// Bit-serial restoring divider of a window sum magnitude by the sample count.
module rshm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rshm_pkg::MAG_W-1:0] i_dividend,
    input  logic [rshm_pkg::CNT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [rshm_pkg::MAG_W-1:0] o_quotient
);

    logic                        r_busy;
    logic [rshm_pkg::DIV_CW-1:0] r_step;
    logic [rshm_pkg::CNT_W:0]    r_rem;
    logic [rshm_pkg::MAG_W-1:0]  r_quo;
    logic [rshm_pkg::CNT_W-1:0]  r_div;
    logic                        r_done;
    logic [rshm_pkg::CNT_W:0]    rem_sh;
    logic                        fits;

    always_comb begin
        rem_sh = {r_rem[rshm_pkg::CNT_W-1:0], r_quo[rshm_pkg::MAG_W-1]};
        fits   = rem_sh >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? rem_sh - {1'b0, r_div} : rem_sh;
                r_quo <= {r_quo[rshm_pkg::MAG_W-2:0], fits};
                if (r_step == rshm_pkg::DIV_CW'(rshm_pkg::MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 1'b1;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ hdl/rshm_chk.sv @@
// Port-level checker of the sensor health monitor, bound to the top level.
`include "redundant_sensor_health_monitor_defines.svh"

module rshm_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_temp_avg_valid,
    input logic               o_hum_avg_valid,
    input logic               o_climate_ok,
    input logic [1:0]         o_severity,
    input logic [2:0]         o_fault_code
);

    // A result word that waits must keep its valid.
    `RSHM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // An accepted sample cannot produce its result in the next cycle.
    `RSHM_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, i_in_valid && !o_in_stall && (!o_out_valid || !i_out_stall), !o_out_valid)

    // Fault code and severity agree on whether anything is wrong.
    `RSHM_ASSERT_SAME(a_code_sev, i_clk, i_rst_n, o_out_valid,
        (o_fault_code == rshm_pkg::FC_NONE) == (o_severity == rshm_pkg::SEV_OK))

    // Climate cannot be reported good while either average is empty.
    `RSHM_ASSERT_SAME(a_climate, i_clk, i_rst_n, o_out_valid && o_climate_ok,
        o_temp_avg_valid && o_hum_avg_valid)

endmodule

bind redundant_sensor_health_monitor rshm_chk u_rshm_chk (.*);
